@@ hw/rtl/websocket_frame_deframer_macros.svh @@
// ----------------------------------------------------------------------------
// websocket frame deframer assertion macros
// shared concurrent assertion forms, clocked on clk_i and held off in reset
// ----------------------------------------------------------------------------
`ifndef WEBSOCKET_FRAME_DEFRAMER_MACROS_SVH
`define WEBSOCKET_FRAME_DEFRAMER_MACROS_SVH

// same-cycle implication
`define WSD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define WSD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/wsd_pkg.sv @@
// ----------------------------------------------------------------------------
// wsd_pkg
// constants shared by the websocket frame deframer and its checker
// ----------------------------------------------------------------------------
`default_nettype none

package wsd_pkg;

  localparam int unsigned HEADER_BYTES = 6;
  localparam int unsigned MAX_PAYLOAD  = 125;

  // input transaction modes
  localparam logic [1:0] MODE_BYTE    = 2'd0;
  localparam logic [1:0] MODE_OPEN    = 2'd1;
  localparam logic [1:0] MODE_TIMEOUT = 2'd2;

  // opcodes
  localparam logic [3:0] OPC_TEXT  = 4'h1;
  localparam logic [3:0] OPC_CLOSE = 4'h8;

  // result kinds
  localparam logic [2:0] KIND_PAYLOAD  = 3'd0;
  localparam logic [2:0] KIND_CLOSE    = 3'd1;
  localparam logic [2:0] KIND_TOO_LONG = 3'd2;
  localparam logic [2:0] KIND_REJECT   = 3'd3;
  localparam logic [2:0] KIND_EMPTY    = 3'd4;

  // frame disposition, equal to the kind reported at frame end, but an empty accepted frame reports KIND_EMPTY
  localparam logic [1:0] DISP_ACCEPT   = 2'd0;
  localparam logic [1:0] DISP_CLOSE    = 2'd1;
  localparam logic [1:0] DISP_TOO_LONG = 2'd2;
  localparam logic [1:0] DISP_REJECT   = 2'd3;

endpackage

`default_nettype wire

@@ hw/rtl/websocket_frame_deframer.sv @@
// ----------------------------------------------------------------------------
// websocket_frame_deframer
// unmasks small websocket client frames from a byte stream, when not stalled one byte a cycle
// ----------------------------------------------------------------------------
// path: an accepted transaction enters the input register, then the single
//   decode stage writes its result into the result register
// throughput: one transaction per cycle unless the result stream stalls
// reset: link closed, header counter cleared, both stage registers empty
// ----------------------------------------------------------------------------
`default_nettype none

module websocket_frame_deframer
  import wsd_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // input stream
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [7:0] rx_byte
  input  wire logic [1:0] s_axis_tuser,   // [1:0] mode
  // result stream
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,   // [7:0] payload_byte
  output logic [2:0]      m_axis_tuser,   // [2:0] kind
  output logic            m_axis_tlast    // last byte of a message
);

  localparam logic [2:0] HdrDone = 3'(HEADER_BYTES);
  localparam logic [6:0] MaxLen  = 7'(MAX_PAYLOAD);

  // input register
  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic [1:0] in_mode_q;

  // deframer state
  logic            link_open_q, link_open_d;
  logic [2:0]      hdr_cnt_q, hdr_cnt_d;
  logic [3:0]      opcode_q, opcode_d;
  logic            final_q, final_d;
  logic            mask_set_q, mask_set_d;
  logic [6:0]      len_q, len_d;
  logic [3:0][7:0] mask_q, mask_d;
  logic [6:0]      pidx_q, pidx_d;
  logic [1:0]      disp_q, disp_d;

  // result register
  logic       out_vld_q, out_vld_d;
  logic [2:0] out_kind_q, out_kind_d;
  logic [7:0] out_byte_q, out_byte_d;
  logic       out_last_q, out_last_d;

  logic       advance;
  logic       in_take;
  logic [1:0] hdr_mask_idx;
  logic [1:0] disp_new;
  logic       pay_end;

  // the decode stage moves when the result register is free or being drained
  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= s_axis_tdata;
      in_mode_q <= s_axis_tuser;
    end
  end

  // mask byte slot for header bytes two to five
  assign hdr_mask_idx = 2'(hdr_cnt_q - 3'd2);

  // classification at the last header byte, first match wins
  always_comb begin
    priority if (!final_q || (opcode_q != OPC_TEXT && opcode_q != OPC_CLOSE)) begin
      disp_new = DISP_REJECT;
    end else if (len_q >= MaxLen) begin
      disp_new = DISP_TOO_LONG;
    end else if (opcode_q == OPC_CLOSE) begin
      disp_new = DISP_CLOSE;
    end else begin
      disp_new = DISP_ACCEPT;
    end
  end

  assign pay_end = ({1'b0, pidx_q} + 8'd1) >= {1'b0, len_q};

  always_comb begin
    link_open_d = link_open_q;
    hdr_cnt_d   = hdr_cnt_q;
    opcode_d    = opcode_q;
    final_d     = final_q;
    mask_set_d  = mask_set_q;
    len_d       = len_q;
    mask_d      = mask_q;
    pidx_d      = pidx_q;
    disp_d      = disp_q;
    out_vld_d   = out_vld_q && !m_axis_tready;
    out_kind_d  = out_kind_q;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;

    if (advance) begin
      out_vld_d  = 1'b0;
      out_kind_d = KIND_PAYLOAD;
      out_byte_d = 8'd0;
      out_last_d = 1'b0;
      priority if (in_mode_q == MODE_OPEN) begin
        // open also drops any partial frame
        link_open_d = 1'b1;
        hdr_cnt_d   = 3'd0;
        pidx_d      = 7'd0;
      end else if (in_mode_q == MODE_TIMEOUT) begin
        hdr_cnt_d = 3'd0;
        pidx_d    = 7'd0;
      end else if (in_mode_q == MODE_BYTE && link_open_q) begin
        if (hdr_cnt_q < HdrDone) begin
          // header phase
          if (hdr_cnt_q == 3'd0) begin
            final_d  = in_byte_q[7];
            opcode_d = in_byte_q[3:0];
          end else if (hdr_cnt_q == 3'd1) begin
            mask_set_d = in_byte_q[7];
            len_d      = in_byte_q[6:0];
            mask_d     = '0;
          end else if (mask_set_q) begin
            mask_d[hdr_mask_idx] = in_byte_q;
          end
          hdr_cnt_d = hdr_cnt_q + 3'd1;
          if (hdr_cnt_q == HdrDone - 3'd1) begin
            disp_d = disp_new;
            pidx_d = 7'd0;
            if (len_q == 7'd0) begin
              // empty frame reports at once
              hdr_cnt_d = 3'd0;
              out_vld_d = 1'b1;
              if (disp_new == DISP_ACCEPT) begin
                out_kind_d = KIND_EMPTY;
              end else begin
                out_kind_d = {1'b0, disp_new};
                if (disp_new == DISP_CLOSE) begin
                  link_open_d = 1'b0;
                end
              end
            end
          end
        end else begin
          // payload phase
          pidx_d = pidx_q + 7'd1;
          if (disp_q == DISP_ACCEPT) begin
            out_vld_d  = 1'b1;
            out_kind_d = KIND_PAYLOAD;
            out_byte_d = in_byte_q ^ mask_q[pidx_q[1:0]];
            out_last_d = pay_end;
            if (pay_end) begin
              hdr_cnt_d = 3'd0;
              pidx_d    = 7'd0;
            end
          end else if (pay_end) begin
            // skipped frame ends with one report
            hdr_cnt_d  = 3'd0;
            pidx_d     = 7'd0;
            out_vld_d  = 1'b1;
            out_kind_d = {1'b0, disp_q};
            if (disp_q == DISP_CLOSE) begin
              link_open_d = 1'b0;
            end
          end
        end
      end else begin
        // byte on a closed link or unused mode: nothing to do
        out_vld_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_open_q <= 1'b0;
      hdr_cnt_q   <= 3'd0;
      opcode_q    <= 4'd0;
      final_q     <= 1'b0;
      mask_set_q  <= 1'b0;
      len_q       <= 7'd0;
      mask_q      <= '0;
      pidx_q      <= 7'd0;
      disp_q      <= DISP_ACCEPT;
      out_vld_q   <= 1'b0;
    end else begin
      link_open_q <= link_open_d;
      hdr_cnt_q   <= hdr_cnt_d;
      opcode_q    <= opcode_d;
      final_q     <= final_d;
      mask_set_q  <= mask_set_d;
      len_q       <= len_d;
      mask_q      <= mask_d;
      pidx_q      <= pidx_d;
      disp_q      <= disp_d;
      out_vld_q   <= out_vld_d;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    out_kind_q <= out_kind_d;
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tdata  = out_byte_q;
  assign m_axis_tlast  = out_last_q;

endmodule

`default_nettype wire

@@ hw/rtl/wsd_checker.sv @@
// ----------------------------------------------------------------------------
// wsd_checker
// port-level checks on the websocket frame deframer result stream
// ----------------------------------------------------------------------------
`default_nettype none

`include "websocket_frame_deframer_macros.svh"

module wsd_checker
  import wsd_pkg::*;
(
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       s_axis_tready,
  input wire logic       m_axis_tvalid,
  input wire logic       m_axis_tready,
  input wire logic [7:0] m_axis_tdata,
  input wire logic [2:0] m_axis_tuser,
  input wire logic       m_axis_tlast
);

  // an empty result register never holds off the input
  `WSD_ASSERT_IMP(a_ready_when_empty, !m_axis_tvalid, s_axis_tready,
    "input stalled with no result waiting")
  `WSD_ASSERT_IMP(a_kind_range, m_axis_tvalid, m_axis_tuser <= KIND_EMPTY,
    "kind out of range")
  `WSD_ASSERT_IMP(a_last_payload, m_axis_tvalid && m_axis_tlast,
    m_axis_tuser == KIND_PAYLOAD, "last on a report")
  `WSD_ASSERT_IMP(a_report_zero, m_axis_tvalid && m_axis_tuser != KIND_PAYLOAD,
    m_axis_tdata == 8'd0 && !m_axis_tlast, "report carries data")
  `WSD_ASSERT_NXT(a_hold, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast),
    "stalled result changed")

endmodule

bind websocket_frame_deframer wsd_checker u_wsd_checker (.*);

`default_nettype wire
